// File: design/wprw_pkg.sv
// ----------------------------------------------------------------------------
// Writer-preferring reader-writer lock: shared package
// Operation and fault codes, limits, and the lock state and result records.
// ----------------------------------------------------------------------------
package wprw_pkg;

	localparam int unsigned FUNC_W   = 3;
	localparam int unsigned TID_W    = 8;
	localparam int unsigned FAULT_W  = 3;
	localparam int unsigned RCNT_W   = 16;
	localparam int unsigned WCNT_W   = 9;

	// Waiting-writer and wake-token counts saturate at this value.
	localparam logic [WCNT_W-1:0] MAX_THREADS = WCNT_W'(256);
	// A read entry may not take the reader count past this value.
	localparam logic [RCNT_W-1:0] MAX_READERS = RCNT_W'(65535);

	typedef enum logic [FUNC_W-1:0] {
		FN_READ_ENTER  = 3'd0,
		FN_WRITE_ENTER = 3'd1,
		FN_WRITE_RETRY = 3'd2,
		FN_TRY_READ    = 3'd3,
		FN_TRY_WRITE   = 3'd4,
		FN_EXIT        = 3'd5,
		FN_TRY_UPGRADE = 3'd6,
		FN_DOWNGRADE   = 3'd7
	} func_t;

	typedef enum logic [FAULT_W-1:0] {
		FLT_NONE          = 3'd0,
		FLT_SELF_LOCK     = 3'd1,
		FLT_NOT_OWNER     = 3'd2,
		FLT_NOT_HOLDER    = 3'd3,
		FLT_READ_OVERFLOW = 3'd4
	} fault_t;

	typedef struct packed {
		logic [RCNT_W-1:0] reader_total;
		logic              owner_valid;
		logic [TID_W-1:0]  owner_thread;
		logic [WCNT_W-1:0] waiting_writers;
		logic              reader_gate;
		logic [WCNT_W-1:0] writer_tokens;
	} lock_state_t;

	typedef struct packed {
		logic              granted;
		fault_t            fault;
		logic              wake_writer;
		logic              read_gate_open;
		logic              read_held;
		logic              write_held;
		logic              lock_held;
		logic [RCNT_W-1:0] reader_count;
		logic [WCNT_W-1:0] writers_waiting_count;
		logic [WCNT_W-1:0] wake_tokens_left;
	} result_t;

endpackage

// File: design/wprw_step.sv
// ----------------------------------------------------------------------------
// Writer-preferring reader-writer lock: decision logic
// Computes the next lock state and the result for one request.
// ----------------------------------------------------------------------------
module wprw_step (
	input  wprw_pkg::func_t                   func,
	input  logic [wprw_pkg::TID_W-1:0]        thread_id,
	input  wprw_pkg::lock_state_t             cur,
	output wprw_pkg::lock_state_t             nxt,
	output wprw_pkg::result_t                 res
);

	localparam logic [wprw_pkg::RCNT_W-1:0] RCNT_ONE = wprw_pkg::RCNT_W'(1);

	always_comb begin
		wprw_pkg::lock_state_t st;
		logic                  granted;
		wprw_pkg::fault_t      fault;
		logic                  woke;
		logic                  is_owner;
		logic                  free_lock;
		logic                  run_wake;
		logic                  wheld;
		logic                  lheld;

		st        = cur;
		granted   = 1'b0;
		fault     = wprw_pkg::FLT_NONE;
		woke      = 1'b0;
		run_wake  = 1'b0;
		is_owner  = cur.owner_valid && (cur.owner_thread == thread_id);
		free_lock = !cur.owner_valid && (cur.reader_total == '0);

		case (func)
			wprw_pkg::FN_READ_ENTER, wprw_pkg::FN_TRY_READ: begin
				if (!cur.owner_valid && (cur.waiting_writers == '0)) begin
					if (cur.reader_total >= wprw_pkg::MAX_READERS) begin
						fault = wprw_pkg::FLT_READ_OVERFLOW;
					end else begin
						st.reader_total = cur.reader_total + 1'b1;
						granted         = 1'b1;
					end
				end else if (func == wprw_pkg::FN_READ_ENTER) begin
					st.reader_gate = 1'b0;
				end
			end
			wprw_pkg::FN_WRITE_ENTER: begin
				if (is_owner) begin
					fault = wprw_pkg::FLT_SELF_LOCK;
				end else if (free_lock) begin
					st.owner_valid  = 1'b1;
					st.owner_thread = thread_id;
					st.reader_gate  = 1'b0;
					granted         = 1'b1;
				end else begin
					if (cur.waiting_writers < wprw_pkg::MAX_THREADS) begin
						st.waiting_writers = cur.waiting_writers + 1'b1;
					end
					st.reader_gate = 1'b0;
				end
			end
			wprw_pkg::FN_WRITE_RETRY: begin
				if (cur.writer_tokens != '0) begin
					st.writer_tokens = cur.writer_tokens - 1'b1;
					if (free_lock) begin
						if (cur.waiting_writers != '0) begin
							st.waiting_writers = cur.waiting_writers - 1'b1;
						end
						st.owner_valid  = 1'b1;
						st.owner_thread = thread_id;
						granted         = 1'b1;
					end
					st.reader_gate = 1'b0;
				end
			end
			wprw_pkg::FN_TRY_WRITE: begin
				if (is_owner) begin
					fault = wprw_pkg::FLT_SELF_LOCK;
				end else if (free_lock) begin
					st.owner_valid  = 1'b1;
					st.owner_thread = thread_id;
					st.reader_gate  = 1'b0;
					granted         = 1'b1;
				end
			end
			wprw_pkg::FN_EXIT: begin
				if (is_owner) begin
					st.owner_valid = 1'b0;
					run_wake       = 1'b1;
				end else if (cur.owner_valid || (cur.reader_total == '0)) begin
					fault = wprw_pkg::FLT_NOT_HOLDER;
				end else begin
					st.reader_total = cur.reader_total - 1'b1;
					run_wake        = 1'b1;
				end
			end
			wprw_pkg::FN_TRY_UPGRADE: begin
				if (is_owner) begin
					fault = wprw_pkg::FLT_SELF_LOCK;
				end else if (!cur.owner_valid && (cur.reader_total == RCNT_ONE)) begin
					st.reader_total = '0;
					st.owner_valid  = 1'b1;
					st.owner_thread = thread_id;
					st.reader_gate  = 1'b0;
					granted         = 1'b1;
				end
			end
			wprw_pkg::FN_DOWNGRADE: begin
				if (!is_owner) begin
					fault = wprw_pkg::FLT_NOT_OWNER;
				end else begin
					st.owner_valid  = 1'b0;
					st.reader_total = RCNT_ONE;
					st.reader_gate  = (cur.waiting_writers == '0);
					granted         = 1'b1;
				end
			end
			default: begin
				st = cur;
			end
		endcase

		// After a release: if writers wait, close the reader gate and, once no
		// readers remain and tokens are below their limit, hand one wake token;
		// else reopen the gate. Only an exit gets here, never leaving an owner.
		if (run_wake) begin
			if (st.owner_valid) begin
				st.reader_gate = 1'b0;
			end else if (st.waiting_writers != '0) begin
				st.reader_gate = 1'b0;
				if ((st.reader_total == '0) && (st.writer_tokens < wprw_pkg::MAX_THREADS)) begin
					st.writer_tokens = st.writer_tokens + 1'b1;
					woke             = 1'b1;
				end
			end else begin
				st.reader_gate = 1'b1;
			end
		end

		wheld = st.owner_valid && (st.owner_thread == thread_id);
		lheld = wheld || (st.reader_total != '0);

		nxt                       = st;
		res.granted               = granted;
		res.fault                 = fault;
		res.wake_writer           = woke;
		res.read_gate_open        = st.reader_gate;
		res.read_held             = lheld && !st.owner_valid;
		res.write_held            = wheld;
		res.lock_held             = lheld;
		res.reader_count          = st.reader_total;
		res.writers_waiting_count = st.waiting_writers;
		res.wake_tokens_left      = st.writer_tokens;
	end

endmodule

// File: design/writer_preferring_rw_lock.sv
// ----------------------------------------------------------------------------
// Writer-preferring reader-writer lock
// Serializes lock requests from many threads and reports one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the input channel (in_valid, in_stall, func, thread_id).
//   Each accepted transfer produces exactly one result transfer on the output
//   channel (out_valid, out_stall and the result fields), in request order.
//   A request is captured in an input register; the lock decision is then made
//   from that register and the lock state, and the result is loaded into the
//   output register while the lock state updates. Throughput is one request
//   per cycle while the receiver does not stall: the whole decision is a
//   handful of compares and counter steps, and the lock state updates as each
//   result is loaded, so a request sees every earlier request's effect.
//   When the receiver stalls, the output register holds its result, the
//   input register may still take one more request, and then in_stall rises.
//   Asynchronous reset (arst_n low) drops both pipeline registers and returns
//   the lock to: no readers, no owner, no waiting writers, no wake tokens and
//   the reader gate open.
// ----------------------------------------------------------------------------
module writer_preferring_rw_lock (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wprw_pkg::FUNC_W-1:0]        func,
	input  logic [wprw_pkg::TID_W-1:0]         thread_id,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               granted,
	output logic [wprw_pkg::FAULT_W-1:0]       fault,
	output logic                               wake_writer,
	output logic                               read_gate_open,
	output logic                               read_held,
	output logic                               write_held,
	output logic                               lock_held,
	output logic [wprw_pkg::RCNT_W-1:0]        reader_count,
	output logic [wprw_pkg::WCNT_W-1:0]        writers_waiting_count,
	output logic [wprw_pkg::WCNT_W-1:0]        wake_tokens_left
);

	// Input register holding the request under decision.
	logic                               valid_s1;
	wprw_pkg::func_t                    func_s1;
	logic [wprw_pkg::TID_W-1:0]         tid_s1;

	// Output register holding the finished result.
	logic                               valid_s2;
	wprw_pkg::result_t                  res_s2;

	wprw_pkg::lock_state_t              lock_q;
	wprw_pkg::lock_state_t              lock_nxt;
	wprw_pkg::result_t                  res_nxt;

	logic                               out_free;
	logic                               adv_s1;
	logic                               take_in;

	// The output register can take a new result when it is empty or its
	// transfer completes in this cycle.
	assign out_free = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && out_free;
	assign take_in  = in_valid && !in_stall;
	assign in_stall = valid_s1 && !out_free;

	wprw_step u_step (
		.func      (func_s1),
		.thread_id (tid_s1),
		.cur       (lock_q),
		.nxt       (lock_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1 <= wprw_pkg::func_t'(func);
			tid_s1  <= thread_id;
		end
	end

	// Lock state commits exactly when a request moves into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q.reader_total    <= '0;
			lock_q.owner_valid     <= 1'b0;
			lock_q.owner_thread    <= '0;
			lock_q.waiting_writers <= '0;
			lock_q.reader_gate     <= 1'b1;
			lock_q.writer_tokens   <= '0;
		end else if (adv_s1) begin
			lock_q <= lock_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid             = valid_s2;
	assign granted               = res_s2.granted;
	assign fault                 = res_s2.fault;
	assign wake_writer           = res_s2.wake_writer;
	assign read_gate_open        = res_s2.read_gate_open;
	assign read_held             = res_s2.read_held;
	assign write_held            = res_s2.write_held;
	assign lock_held             = res_s2.lock_held;
	assign reader_count          = res_s2.reader_count;
	assign writers_waiting_count = res_s2.writers_waiting_count;
	assign wake_tokens_left      = res_s2.wake_tokens_left;

endmodule
